// ===== hw/rtl/dtkd_pkg.sv =====
// Shared types and constants for the dual timer key debouncer.
// Holds the request and result payload structs, per-key state and register codes.
// No dependencies.
package dtkd_pkg;

  localparam int TMR_W   = 7;
  localparam int RAW_W   = 16;
  localparam int ELAP_W  = 8;
  localparam int ROWIN_W = 3;

  localparam logic [TMR_W-1:0] DEBOUNCE_RESET = 7'd5;
  localparam logic [TMR_W-1:0] QUIET_RESET    = 7'd50;

  // register index codes (byte address bit 2)
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_QUIET    = 1'b1;

  typedef struct packed {
    logic [ROWIN_W-1:0] row_index;
    logic [RAW_W-1:0]   raw_row;
    logic [ELAP_W-1:0]  elapsed_ms;
    logic               scan_changed;
    logic               last_row;
  } sample_t;

  typedef struct packed {
    logic [ROWIN_W-1:0] out_row_index;
    logic [RAW_W-1:0]   cooked_row;
    logic               row_changed;
    logic               scan_any_changed;
    logic               out_last_row;
  } result_t;

  typedef struct packed {
    logic [TMR_W-1:0] debounce_ms;
    logic [TMR_W-1:0] quiet_ms;
  } cfg_t;

  typedef struct packed {
    logic             expired;
    logic [TMR_W-1:0] short_tmr;
    logic [TMR_W-1:0] long_tmr;
  } key_st_t;

  localparam key_st_t KEY_RESET = '{expired: 1'b0, short_tmr: '0, long_tmr: QUIET_RESET};

endpackage

// ===== hw/rtl/dtkd_cfg.sv =====
// APB-style configuration registers: debounce and quiet window lengths.
// Depends on dtkd_pkg.
module dtkd_cfg
  import dtkd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms <= DEBOUNCE_RESET;
      cfg.quiet_ms    <= QUIET_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_DEBOUNCE: cfg.debounce_ms <= pwdata[TMR_W-1:0];
        REG_QUIET:    cfg.quiet_ms    <= pwdata[TMR_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEBOUNCE: prdata = {{(32-TMR_W){1'b0}}, cfg.debounce_ms};
      REG_QUIET:    prdata = {{(32-TMR_W){1'b0}}, cfg.quiet_ms};
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/dtkd_key.sv =====
// Next-state logic of one key: timer update, then eager/deferred transfer.
// Purely combinational. Depends on dtkd_pkg.
module dtkd_key
  import dtkd_pkg::*;
(
  input  key_st_t           cur,
  input  logic              cooked,
  input  logic              raw,
  input  logic [ELAP_W-1:0] elapsed,
  input  cfg_t              cfg,
  input  logic              xfer_en,
  output key_st_t           nxt,
  output logic              cooked_nxt,
  output logic              expire_hit
);

  key_st_t upd;
  logic    upd_cooked;

  function automatic logic [TMR_W-1:0] count_down(input logic [TMR_W-1:0] t,
                                                  input logic [ELAP_W-1:0] e);
    logic [ELAP_W-1:0] t8;
    t8 = ELAP_W'(t);
    return (t8 > e) ? TMR_W'(t8 - e) : '0;
  endfunction

  // timer update
  always_comb begin
    upd        = cur;
    upd_cooked = cooked;
    expire_hit = 1'b0;
    if (elapsed != '0) begin
      if (!cur.expired && cur.short_tmr != '0) begin
        if (ELAP_W'(cur.long_tmr) <= elapsed) begin
          upd.expired = 1'b1;
          expire_hit  = 1'b1;
        end else if (ELAP_W'(cur.short_tmr) <= elapsed) begin
          upd.short_tmr = '0;
          upd_cooked    = raw;
          if (raw != cooked) begin
            upd.expired  = 1'b0;
            upd.long_tmr = cfg.quiet_ms;
          end
        end
      end
      if (!upd.expired) upd.long_tmr = count_down(upd.long_tmr, elapsed);
      if (upd.short_tmr != '0) upd.short_tmr = count_down(upd.short_tmr, elapsed);
    end
  end

  // transfer: restart the short window on a difference; toggle eagerly when idle or expired
  always_comb begin
    nxt        = upd;
    cooked_nxt = upd_cooked;
    if (xfer_en && (raw != upd_cooked)) begin
      nxt.short_tmr = cfg.debounce_ms;
      if (upd.expired || upd.short_tmr == '0) begin
        nxt.expired  = 1'b0;
        nxt.long_tmr = cfg.quiet_ms;
        cooked_nxt   = ~upd_cooked;
      end
    end
  end

endmodule

// ===== hw/rtl/dtkd_row.sv =====
// Per-row key state store, rescan flag and scan change accumulator.
// Instantiates dtkd_key once per column. Depends on dtkd_pkg.
module dtkd_row
  import dtkd_pkg::*;
#(
  parameter int ROWS = 8,
  parameter int COLS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  sample_t sample,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  key_st_t [COLS-1:0] key_mem    [ROWS];
  logic    [COLS-1:0] cooked_mem [ROWS];
  logic               rescan_flag;
  logic               scan_change_acc;

  logic               row_ok;
  logic [ROW_W-1:0]   ridx;
  key_st_t [COLS-1:0] key_cur;
  key_st_t [COLS-1:0] key_nxt;
  logic    [COLS-1:0] ck_cur;
  logic    [COLS-1:0] ck_nxt;
  logic    [COLS-1:0] raw_k;
  logic    [COLS-1:0] hits;
  logic               rescan_next;
  logic               xfer_en;
  logic               row_chg;
  logic               any_chg;

  assign row_ok  = 32'(sample.row_index) < ROWS;
  assign ridx    = ROW_W'(sample.row_index);
  assign key_cur = key_mem[ridx];
  assign ck_cur  = cooked_mem[ridx];

  assign rescan_next = (row_ok && sample.elapsed_ms != '0) ? (|hits) : rescan_flag;
  assign xfer_en     = sample.scan_changed || rescan_next;

  for (genvar c = 0; c < COLS; c++) begin : g_col
    if (c < RAW_W) begin : g_raw
      assign raw_k[c] = sample.raw_row[c];
    end else begin : g_zero
      assign raw_k[c] = 1'b0;
    end
    dtkd_key u_key (
      .cur       (key_cur[c]),
      .cooked    (ck_cur[c]),
      .raw       (raw_k[c]),
      .elapsed   (sample.elapsed_ms),
      .cfg       (cfg),
      .xfer_en   (xfer_en),
      .nxt       (key_nxt[c]),
      .cooked_nxt(ck_nxt[c]),
      .expire_hit(hits[c])
    );
  end

  for (genvar b = 0; b < RAW_W; b++) begin : g_out
    if (b < COLS) begin : g_key
      assign result.cooked_row[b] = row_ok && ck_nxt[b];
    end else begin : g_pad
      assign result.cooked_row[b] = 1'b0;
    end
  end

  assign row_chg = row_ok && (ck_nxt != ck_cur);
  assign any_chg = scan_change_acc || row_chg;

  assign result.out_row_index    = sample.row_index;
  assign result.row_changed      = row_chg;
  assign result.scan_any_changed = any_chg;
  assign result.out_last_row     = sample.last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        key_mem[r]    <= {COLS{KEY_RESET}};
        cooked_mem[r] <= '0;
      end
      rescan_flag     <= 1'b0;
      scan_change_acc <= 1'b0;
    end else if (step) begin
      if (row_ok) begin
        key_mem[ridx]    <= key_nxt;
        cooked_mem[ridx] <= ck_nxt;
      end
      rescan_flag     <= rescan_next;
      scan_change_acc <= sample.last_row ? 1'b0 : any_chg;
    end
  end

endmodule

// ===== hw/rtl/dual_timer_key_debouncer.sv =====
// Dual timer key debouncer: one key matrix row per request, one result per request.
// A request waits in the input register, then moves into the result register.
// Throughput: one request per cycle unless the result register is full and not
// taken; the key state store row read-modify-write lies between the two registers.
// Reset (rst, synchronous): timers idle, long timers at 50, cooked bits clear,
// debounce 5 and quiet 50; no clearing pass, the block is ready right after reset.
module dual_timer_key_debouncer
  import dtkd_pkg::*;
#(
  parameter int ROWS = 8,
  parameter int COLS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        sample_valid,
  output logic        sample_ready,
  input  sample_t     sample,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  sample_t in_q;
  logic    in_vld;
  result_t row_res;
  result_t out_q;
  logic    out_vld;
  logic    advance;

  // Move the held request into the result register whenever that register
  // is empty or being drained this cycle; the key state is written at the
  // same edge, so back-to-back requests to one row see fresh state.
  assign advance      = in_vld && (!out_vld || result_ready);
  assign sample_ready = !in_vld || advance;

  dtkd_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  dtkd_row #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_row (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .sample(in_q),
    .cfg   (cfg),
    .result(row_res)
  );

  // Input register: hold a request until it advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      in_q <= sample;
    end
  end

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (result_ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= row_res;
    end
  end

  assign result_valid = out_vld;
  assign result       = out_q;

  // Stalled input only when both stages are full and the result is not taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> (in_vld && out_vld && !result_ready))
    else $error("input stalled without a full pipeline");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("advanced request did not produce a result");

  a_scan_acc: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.row_changed || result.scan_any_changed))
    else $error("row change not reflected in scan accumulator");

  a_bad_row: assert property (@(posedge clk) disable iff (rst)
    (result_valid && 32'(result.out_row_index) >= ROWS)
      |-> (result.cooked_row == '0 && !result.row_changed))
    else $error("out of range row produced key data");

endmodule
